/* rtl/ntt_with_kred_reduction_assert.svh */
// Assertion macros used by the port-level checker of the NTT block.
// Depends on nothing; include by bare file name.
`ifndef NTT_WITH_KRED_REDUCTION_ASSERT_SVH
`define NTT_WITH_KRED_REDUCTION_ASSERT_SVH

// same-cycle implication
`define NKR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntt_kred assertion failed");

// next-cycle implication
`define NKR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntt_kred assertion failed");

`endif

/* rtl/ntt_kred_pkg.sv */
// Shared constants, types and K-RED helper functions for the NTT block.
// No dependencies.
package ntt_kred_pkg;

    localparam int COEFF_COUNT = 512;
    localparam int ADDR_W      = 9;
    localparam int WORK_W      = 32;
    localparam int TW_W        = 14;
    localparam int RES_W       = 14;

    localparam logic [13:0] QMOD          = 14'd12289;
    localparam logic [13:0] N_INV         = 14'd12265;
    localparam logic [13:0] SCALE_INV_RST = 14'd8193;
    localparam logic [13:0] FINAL_SC_RST  = 14'd1;

    // floor(2^44 / 12289): quotient estimate is the top 20 bits of magnitude times this
    localparam logic [31:0] CANON_RECIP   = 32'((64'd1 << 44) / 64'd12289);

    localparam logic [1:0] FUNC_LOAD_COEFF = 2'd0;
    localparam logic [1:0] FUNC_LOAD_TW    = 2'd1;
    localparam logic [1:0] FUNC_RUN        = 2'd2;
    localparam logic [1:0] FUNC_READ       = 2'd3;

    localparam logic [1:0] CFG_DIRECTION   = 2'd0;
    localparam logic [1:0] CFG_SCALE_INV   = 2'd1;
    localparam logic [1:0] CFG_FINAL_SCALE = 2'd2;

    typedef struct packed {
        logic        start;
        logic [31:0] x;
    } canon_req_t;

    typedef struct packed {
        logic        done;
        logic [13:0] value;
    } canon_rsp_t;

    function automatic logic fwd_reduce(input logic [9:0] m);
        return (m == 10'd4) || (m == 10'd32) || (m == 10'd256);
    endfunction

    function automatic logic inv_lazy(input logic [9:0] m);
        return (m == 10'd512) || (m == 10'd128) || (m == 10'd32) || (m == 10'd8);
    endfunction

    function automatic logic [31:0] kred(input logic [31:0] x);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = {20'd0, x[11:0]};
        hi = {{12{x[31]}}, x[31:12]};
        return 32'(3 * lo) - hi;
    endfunction

    function automatic logic [31:0] kred9(input logic [11:0] a, input logic [11:0] b,
                                          input logic [31:0] c);
        logic [31:0] a32;
        logic [31:0] b32;
        a32 = {20'd0, a};
        b32 = {20'd0, b};
        return 32'(9 * a32) - 32'(3 * b32) + c;
    endfunction

    function automatic logic [31:0] kred2(input logic [31:0] x);
        return kred9(x[11:0], x[23:12], {{24{x[31]}}, x[31:24]});
    endfunction

endpackage

/* rtl/ntt_kred_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ntt_kred_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ntt_kred_canon.sv */
// Pipelined canonical residue modulo 12289 of a 32-bit two's complement word.
// Reciprocal multiply, one correcting subtract; done pulses via v1, v2, v3 regs.
// Depends on ntt_kred_pkg.
module ntt_kred_canon (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ntt_kred_pkg::canon_req_t req,
    output ntt_kred_pkg::canon_rsp_t rsp
);

    logic [31:0] mag_reg;
    logic        neg_reg;
    logic [63:0] prod_reg;
    logic [31:0] rem_reg;
    logic [13:0] r_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        done_reg;
    logic [19:0] quot;
    logic [31:0] qm;
    logic [31:0] fold;

    assign quot = prod_reg[63:44];
    assign qm   = {12'd0, quot} * {18'd0, ntt_kred_pkg::QMOD};
    assign fold = rem_reg - {18'd0, ntt_kred_pkg::QMOD};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.x[31];
            mag_reg <= req.x[31] ? (~req.x) + 32'd1 : req.x;
        end
        if (v1_reg)
        begin
            prod_reg <= {32'd0, mag_reg} * {32'd0, ntt_kred_pkg::CANON_RECIP};
        end
        if (v2_reg)
        begin
            rem_reg <= mag_reg - qm;
        end
        if (v3_reg)
        begin
            r_reg <= (rem_reg >= {18'd0, ntt_kred_pkg::QMOD}) ? fold[13:0] : rem_reg[13:0];
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = (neg_reg && (r_reg != 14'd0)) ? ntt_kred_pkg::QMOD - r_reg : r_reg;

endmodule

/* rtl/ntt_with_kred_reduction.sv */
// Top level of the 512-point NTT modulo 12289 with lazy K-RED reduction.
// Depends on ntt_kred_pkg, ntt_kred_ram and ntt_kred_canon.
//
// A coefficient or twiddle load is accepted in idle, its result is registered at
// the output from ST_DONE, and the next item is taken once the output is free and
// the block is back in idle. A read fetches the word and passes it through the
// residue pipeline of ntt_kred_canon before ST_DONE. A run holds the block: each
// twiddle group first takes the prescale residue, each butterfly (plus ST_BF_RED2
// in the inverse's scaling stage) uses the single read port of the work memory,
// the inverse computes its scale factors before that stage, and a final pass, one
// entry at a time, brings all 512 entries to canonical form.
// The block accepts a new item while the previous result waits at the output.
module ntt_with_kred_reduction (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [8:0] index, [24:9] value, [31:25] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [13:0] read_value, [15:14] zero
    output logic [1:0]  m_tuser,   // [1:0] done_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    typedef enum logic [21:0] {
        ST_IDLE     = 22'h000001,
        ST_DONE     = 22'h000002,
        ST_RD_WAIT  = 22'h000004,
        ST_RD_CANON = 22'h000008,
        ST_TW_RD    = 22'h000010,
        ST_TW_WAIT  = 22'h000020,
        ST_TW_CANON = 22'h000040,
        ST_BF_RDU   = 22'h000080,
        ST_BF_RDV   = 22'h000100,
        ST_BF_CAP   = 22'h000200,
        ST_BF_MUL   = 22'h000400,
        ST_BF_RED   = 22'h000800,
        ST_BF_RED2  = 22'h001000,
        ST_BF_WRU   = 22'h002000,
        ST_BF_WRV   = 22'h004000,
        ST_FS_S0    = 22'h008000,
        ST_FS_S0W   = 22'h010000,
        ST_FS_S1A   = 22'h020000,
        ST_FS_S1B   = 22'h040000,
        ST_CP_RD    = 22'h080000,
        ST_CP_WAIT  = 22'h100000,
        ST_CP_CANON = 22'h200000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic        dir_reg;
    logic [13:0] scale_reg;
    logic [13:0] fscale_reg;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [13:0] out_val_reg;
    logic [1:0]  res_kind_reg;
    logic [13:0] res_val_reg;

    logic [9:0]  m_reg;
    logic [8:0]  t_reg;
    logic [8:0]  i_reg;
    logic [7:0]  jj_reg;
    logic [8:0]  j1_reg;
    logic [8:0]  k_reg;
    logic        final_reg;

    logic [13:0] w_reg;
    logic [13:0] s0_reg;
    logic [13:0] s1_reg;
    logic [31:0] u_reg;
    logic [31:0] v_reg;
    logic [31:0] uk_reg;
    logic [46:0] prod_reg;
    logic [31:0] r1_reg;
    logic [31:0] r2_reg;

    logic        in_accept;
    logic [1:0]  in_func;
    logic [8:0]  in_index;
    logic [15:0] in_value;

    logic        work_we;
    logic [8:0]  work_waddr;
    logic [31:0] work_wdata;
    logic [8:0]  work_raddr;
    logic [31:0] work_rdata;
    logic        tw_we;
    logic [8:0]  tw_raddr;
    logic [13:0] tw_rdata;

    ntt_kred_pkg::canon_req_t canon_req;
    ntt_kred_pkg::canon_rsp_t canon_rsp;

    logic [8:0]  j_addr;
    logic [8:0]  jt_addr;
    logic [8:0]  tw_idx;
    logic [9:0]  grp_count;
    logic        grp_last;
    logic        bf_last;
    logic [31:0] sum_uv;
    logic [31:0] diff_uv;
    logic [31:0] mul_x;
    logic [13:0] mul_c;
    logic [31:0] p32;
    logic [31:0] p_hi;
    logic [31:0] red_val;
    logic [27:0] tw_prod;
    logic [27:0] ninv_fs;
    logic [27:0] ninv_tw;
    logic [27:0] res_fs;

    assign in_func   = s_tuser;
    assign in_index  = s_tdata[8:0];
    assign in_value  = s_tdata[24:9];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_val_reg};

    assign j_addr    = j1_reg + {1'b0, jj_reg};
    assign jt_addr   = j_addr + t_reg;
    assign tw_idx    = dir_reg ? (m_reg[9:1] + i_reg) : (m_reg[8:0] + i_reg);
    assign grp_count = dir_reg ? {1'b0, m_reg[9:1]} : m_reg;
    assign grp_last  = ({1'b0, i_reg} == grp_count - 10'd1);
    assign bf_last   = ({1'b0, jj_reg} == t_reg - 9'd1);
    assign sum_uv    = u_reg + v_reg;
    assign diff_uv   = u_reg - v_reg;
    assign p32       = prod_reg[31:0];
    assign p_hi      = {{9{prod_reg[46]}}, prod_reg[46:24]};
    assign tw_prod   = tw_rdata * scale_reg;
    assign ninv_fs   = ntt_kred_pkg::N_INV * fscale_reg;
    assign ninv_tw   = ntt_kred_pkg::N_INV * tw_rdata;
    assign res_fs    = canon_rsp.value * fscale_reg;

    always_comb
    begin
        if (final_reg)
        begin
            mul_x = sum_uv;
            mul_c = s0_reg;
        end
        else if (dir_reg)
        begin
            mul_x = diff_uv;
            mul_c = w_reg;
        end
        else
        begin
            mul_x = v_reg;
            mul_c = w_reg;
        end
    end

    always_comb
    begin
        if (final_reg)
        begin
            red_val = ntt_kred_pkg::kred(p32);
        end
        else if (dir_reg)
        begin
            red_val = ntt_kred_pkg::inv_lazy(m_reg) ? ntt_kred_pkg::kred(p32)
                                                    : ntt_kred_pkg::kred2(p32);
        end
        else
        begin
            red_val = ntt_kred_pkg::fwd_reduce(m_reg) ?
                      ntt_kred_pkg::kred9(prod_reg[11:0], prod_reg[23:12], p_hi) :
                      ntt_kred_pkg::kred(p32);
        end
    end

    always_comb
    begin
        work_we     = 1'b0;
        work_waddr  = j_addr;
        work_wdata  = '0;
        work_raddr  = j_addr;
        tw_we       = 1'b0;
        tw_raddr    = tw_idx;
        canon_req   = '0;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                work_raddr = in_index;
                work_waddr = in_index;
                work_wdata = {{16{in_value[15]}}, in_value};
                if (in_accept)
                begin
                    case (in_func)
                        ntt_kred_pkg::FUNC_LOAD_COEFF:
                        begin
                            work_we    = 1'b1;
                            state_next = ST_DONE;
                        end
                        ntt_kred_pkg::FUNC_LOAD_TW:
                        begin
                            tw_we      = 1'b1;
                            state_next = ST_DONE;
                        end
                        ntt_kred_pkg::FUNC_RUN:
                        begin
                            state_next = ST_TW_RD;
                        end
                        default:
                        begin
                            state_next = ST_RD_WAIT;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_WAIT:
            begin
                canon_req.start = 1'b1;
                canon_req.x     = work_rdata;
                state_next      = ST_RD_CANON;
            end
            ST_RD_CANON:
            begin
                if (canon_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TW_RD:
            begin
                state_next = ST_TW_WAIT;
            end
            ST_TW_WAIT:
            begin
                canon_req.start = 1'b1;
                canon_req.x     = {4'd0, tw_prod};
                state_next      = ST_TW_CANON;
            end
            ST_TW_CANON:
            begin
                if (canon_rsp.done)
                begin
                    state_next = ST_BF_RDU;
                end
            end
            ST_BF_RDU:
            begin
                state_next = ST_BF_RDV;
            end
            ST_BF_RDV:
            begin
                work_raddr = jt_addr;
                state_next = ST_BF_CAP;
            end
            ST_BF_CAP:
            begin
                state_next = ST_BF_MUL;
            end
            ST_BF_MUL:
            begin
                state_next = ST_BF_RED;
            end
            ST_BF_RED:
            begin
                state_next = final_reg ? ST_BF_RED2 : ST_BF_WRU;
            end
            ST_BF_RED2:
            begin
                state_next = ST_BF_WRU;
            end
            ST_BF_WRU:
            begin
                work_we = 1'b1;
                if (final_reg)
                begin
                    work_wdata = r1_reg;
                end
                else if (dir_reg)
                begin
                    work_wdata = ntt_kred_pkg::inv_lazy(m_reg) ? sum_uv
                                                              : ntt_kred_pkg::kred(sum_uv);
                end
                else
                begin
                    work_wdata = uk_reg + r1_reg;
                end
                state_next = ST_BF_WRV;
            end
            ST_BF_WRV:
            begin
                work_we    = 1'b1;
                work_waddr = jt_addr;
                if (final_reg)
                begin
                    work_wdata = r2_reg;
                end
                else if (dir_reg)
                begin
                    work_wdata = r1_reg;
                end
                else
                begin
                    work_wdata = uk_reg - r1_reg;
                end
                if (!bf_last)
                begin
                    state_next = ST_BF_RDU;
                end
                else if (final_reg)
                begin
                    state_next = ST_CP_RD;
                end
                else if (!grp_last)
                begin
                    state_next = ST_TW_RD;
                end
                else if (dir_reg)
                begin
                    state_next = (m_reg == 10'd4) ? ST_FS_S0 : ST_TW_RD;
                end
                else
                begin
                    state_next = (m_reg == 10'd256) ? ST_CP_RD : ST_TW_RD;
                end
            end
            ST_FS_S0:
            begin
                tw_raddr        = 9'd1;
                canon_req.start = 1'b1;
                canon_req.x     = {4'd0, ninv_fs};
                state_next      = ST_FS_S0W;
            end
            ST_FS_S0W:
            begin
                tw_raddr = 9'd1;
                if (canon_rsp.done)
                begin
                    canon_req.start = 1'b1;
                    canon_req.x     = {4'd0, ninv_tw};
                    state_next      = ST_FS_S1A;
                end
            end
            ST_FS_S1A:
            begin
                if (canon_rsp.done)
                begin
                    canon_req.start = 1'b1;
                    canon_req.x     = {4'd0, res_fs};
                    state_next      = ST_FS_S1B;
                end
            end
            ST_FS_S1B:
            begin
                if (canon_rsp.done)
                begin
                    state_next = ST_BF_RDU;
                end
            end
            ST_CP_RD:
            begin
                work_raddr = k_reg;
                state_next = ST_CP_WAIT;
            end
            ST_CP_WAIT:
            begin
                canon_req.start = 1'b1;
                canon_req.x     = work_rdata;
                state_next      = ST_CP_CANON;
            end
            ST_CP_CANON:
            begin
                work_waddr = k_reg;
                work_wdata = {18'd0, canon_rsp.value};
                if (canon_rsp.done)
                begin
                    work_we    = 1'b1;
                    state_next = (k_reg == 9'(ntt_kred_pkg::COEFF_COUNT - 1)) ?
                                 ST_DONE : ST_CP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dir_reg       <= 1'b0;
            scale_reg     <= ntt_kred_pkg::SCALE_INV_RST;
            fscale_reg    <= ntt_kred_pkg::FINAL_SC_RST;
            out_valid_reg <= 1'b0;
            m_reg         <= '0;
            t_reg         <= '0;
            i_reg         <= '0;
            jj_reg        <= '0;
            j1_reg        <= '0;
            k_reg         <= '0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ntt_kred_pkg::CFG_DIRECTION:   dir_reg    <= cfg_data[0];
                    ntt_kred_pkg::CFG_SCALE_INV:   scale_reg  <= cfg_data;
                    ntt_kred_pkg::CFG_FINAL_SCALE: fscale_reg <= cfg_data;
                    default:                       dir_reg    <= dir_reg;
                endcase
            end
            if (state_reg == ST_DONE && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && in_func == ntt_kred_pkg::FUNC_RUN)
                    begin
                        m_reg     <= dir_reg ? 10'd512 : 10'd1;
                        t_reg     <= dir_reg ? 9'd1 : 9'd256;
                        i_reg     <= '0;
                        jj_reg    <= '0;
                        j1_reg    <= '0;
                        k_reg     <= '0;
                        final_reg <= 1'b0;
                    end
                end
                ST_BF_WRV:
                begin
                    if (!bf_last)
                    begin
                        jj_reg <= jj_reg + 8'd1;
                    end
                    else
                    begin
                        jj_reg <= '0;
                        if (final_reg)
                        begin
                            k_reg <= '0;
                        end
                        else if (!grp_last)
                        begin
                            i_reg  <= i_reg + 9'd1;
                            j1_reg <= j1_reg + {t_reg[7:0], 1'b0};
                        end
                        else
                        begin
                            i_reg  <= '0;
                            j1_reg <= '0;
                            k_reg  <= '0;
                            if (dir_reg)
                            begin
                                t_reg <= {t_reg[7:0], 1'b0};
                                if (m_reg == 10'd4)
                                begin
                                    final_reg <= 1'b1;
                                end
                                else
                                begin
                                    m_reg <= {1'b0, m_reg[9:1]};
                                end
                            end
                            else
                            begin
                                m_reg <= {m_reg[8:0], 1'b0};
                                t_reg <= {1'b0, t_reg[8:1]};
                            end
                        end
                    end
                end
                ST_CP_CANON:
                begin
                    if (canon_rsp.done)
                    begin
                        k_reg <= k_reg + 9'd1;
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && (!out_valid_reg || m_tready))
        begin
            out_kind_reg <= res_kind_reg;
            out_val_reg  <= res_val_reg;
        end
        if (in_accept)
        begin
            res_kind_reg <= in_func;
            res_val_reg  <= '0;
        end
        else if (state_reg == ST_RD_CANON && canon_rsp.done)
        begin
            res_val_reg <= canon_rsp.value;
        end
        else if (state_reg == ST_CP_CANON)
        begin
            res_val_reg <= '0;
        end
        if (state_reg == ST_TW_CANON && canon_rsp.done)
        begin
            w_reg <= canon_rsp.value;
        end
        if (state_reg == ST_FS_S0W && canon_rsp.done)
        begin
            s0_reg <= canon_rsp.value;
        end
        if (state_reg == ST_FS_S1B && canon_rsp.done)
        begin
            s1_reg <= canon_rsp.value;
        end
        if (state_reg == ST_BF_RDV)
        begin
            u_reg <= work_rdata;
        end
        if (state_reg == ST_BF_CAP)
        begin
            v_reg <= work_rdata;
        end
        if (state_reg == ST_BF_MUL)
        begin
            prod_reg <= $signed({{15{mul_x[31]}}, mul_x}) * $signed({33'd0, mul_c});
            uk_reg   <= (!dir_reg && !final_reg && ntt_kred_pkg::fwd_reduce(m_reg)) ?
                        ntt_kred_pkg::kred(u_reg) : u_reg;
        end
        if (state_reg == ST_BF_RED)
        begin
            r1_reg   <= red_val;
            prod_reg <= $signed({{15{diff_uv[31]}}, diff_uv}) * $signed({33'd0, s1_reg});
        end
        if (state_reg == ST_BF_RED2)
        begin
            r2_reg <= ntt_kred_pkg::kred(p32);
        end
    end

    ntt_kred_ram #(
        .WIDTH(ntt_kred_pkg::WORK_W),
        .DEPTH(ntt_kred_pkg::COEFF_COUNT)
    ) u_work_ram (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    ntt_kred_ram #(
        .WIDTH(ntt_kred_pkg::TW_W),
        .DEPTH(ntt_kred_pkg::COEFF_COUNT)
    ) u_tw_ram (
        .clk   (clk),
        .we    (tw_we),
        .waddr (in_index),
        .wdata (in_value[13:0]),
        .raddr (tw_raddr),
        .rdata (tw_rdata)
    );

    ntt_kred_canon u_canon (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (canon_req),
        .rsp   (canon_rsp)
    );

endmodule

/* rtl/ntt_kred_checker.sv */
// Port-level checks for the NTT block, bound to the top level.
// Depends on ntt_kred_pkg and ntt_with_kred_reduction_assert.svh.
`include "ntt_with_kred_reduction_assert.svh"

module ntt_kred_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `NKR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `NKR_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready,
        $stable(m_tdata) && $stable(m_tuser))
    `NKR_ASSERT_NOW(a_zero_unless_read, clk, rst_n,
        m_tvalid && (m_tuser != ntt_kred_pkg::FUNC_READ), m_tdata == 16'd0)
    `NKR_ASSERT_NOW(a_canonical, clk, rst_n, m_tvalid,
        m_tdata < {2'b00, ntt_kred_pkg::QMOD})
    `NKR_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind ntt_with_kred_reduction ntt_kred_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* test/ntt_with_kred_reduction_checker.sv */
// Checker for the 512-point NTT block: watches the input, config and result channels,
// predicts every result from its own copy of the stores and registers, and counts mismatches.
// Depends on ntt_kred_pkg for store depth, constants, function codes and register indexes.
`timescale 1ns / 1ps

module ntt_with_kred_reduction_checker
    import ntt_kred_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    output int          pending,
    output int          errors
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] residue;
    } result_t;

    logic [31:0] coeffs [COEFF_COUNT];
    logic [13:0] twiddles [COEFF_COUNT];
    logic        dir_inverse;
    logic [13:0] scale_inv;
    logic [13:0] final_sc;
    result_t     results_due [$];
    int          mismatch_count;

    function automatic logic [31:0] residue(input logic [31:0] x);
        logic [31:0] mag;
        logic [31:0] r;
        if (x[31])
        begin
            mag = ~x + 32'd1;
            r = mag % 32'd12289;
            return (r != 0) ? 32'd12289 - r : 32'd0;
        end
        return x % 32'd12289;
    endfunction

    function automatic logic [31:0] kred_once(input logic [31:0] x);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = {20'd0, x[11:0]};
        hi = {{12{x[31]}}, x[31:12]};
        return 32'(32'd3 * lo) - hi;
    endfunction

    function automatic logic [31:0] kred_twice(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = {20'd0, x[11:0]};
        b = {20'd0, x[23:12]};
        c = {{24{x[31]}}, x[31:24]};
        return 32'(32'd9 * a) - 32'(32'd3 * b) + c;
    endfunction

    function automatic logic [31:0] kred_twice_product(input logic [31:0] x,
                                                       input logic [31:0] w);
        logic signed [63:0] p;
        logic [31:0]        a;
        logic [31:0]        b;
        logic [31:0]        c;
        p = $signed({{32{x[31]}}, x}) * $signed({32'd0, w});
        a = {20'd0, p[11:0]};
        b = {20'd0, p[23:12]};
        c = p[55:24];
        return 32'(32'd9 * a) - 32'(32'd3 * b) + c;
    endfunction

    function automatic logic [31:0] twiddle_scaled(input int pos);
        return residue(32'({18'd0, twiddles[pos]} * {18'd0, scale_inv}));
    endfunction

    task automatic ntt_forward_pass();
        int          t;
        int          j1;
        logic        red;
        logic [31:0] w;
        logic [31:0] u;
        logic [31:0] v;
        t = COEFF_COUNT;
        for (int m = 1; m < COEFF_COUNT; m *= 2)
        begin
            red = (m == 4) || (m == 32) || (m == 256);
            t /= 2;
            for (int i = 0; i < m; i++)
            begin
                j1 = 2 * i * t;
                w = twiddle_scaled((m + i) % COEFF_COUNT);
                for (int j = j1; j < j1 + t; j++)
                begin
                    if (red)
                    begin
                        u = kred_once(coeffs[j]);
                        v = kred_twice_product(coeffs[j + t], w);
                    end
                    else
                    begin
                        u = coeffs[j];
                        v = kred_once(32'(coeffs[j + t] * w));
                    end
                    coeffs[j] = u + v;
                    coeffs[j + t] = u - v;
                end
            end
        end
    endtask

    task automatic ntt_inverse_pass();
        int          t;
        int          j1;
        logic        lazy;
        logic [31:0] w;
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] n_inv32;
        t = 1;
        for (int m = COEFF_COUNT; m > 2; m /= 2)
        begin
            lazy = (m == 512) || (m == 128) || (m == 32) || (m == 8);
            j1 = 0;
            for (int i = 0; i < m / 2; i++)
            begin
                w = twiddle_scaled((m / 2 + i) % COEFF_COUNT);
                for (int j = j1; j < j1 + t; j++)
                begin
                    u = coeffs[j];
                    v = coeffs[j + t];
                    if (lazy)
                    begin
                        coeffs[j] = u + v;
                        coeffs[j + t] = kred_once(32'((u - v) * w));
                    end
                    else
                    begin
                        coeffs[j] = kred_once(u + v);
                        coeffs[j + t] = kred_twice(32'((u - v) * w));
                    end
                end
                j1 += 2 * t;
            end
            t *= 2;
        end
        n_inv32 = {18'd0, N_INV};
        s0 = residue(32'(n_inv32 * {18'd0, final_sc}));
        s1 = residue(32'(residue(32'(n_inv32 * {18'd0, twiddles[1]})) * {18'd0, final_sc}));
        for (int j = 0; j < t; j++)
        begin
            u = coeffs[j];
            v = coeffs[j + t];
            coeffs[j] = kred_once(32'((u + v) * s0));
            coeffs[j + t] = kred_once(32'((u - v) * s1));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [1:0]  func;
        logic [8:0]  idx;
        logic [15:0] val;
        result_t     want;
        if (!rst_n)
        begin
            for (int k = 0; k < COEFF_COUNT; k++)
            begin
                coeffs[k] = '0;
                twiddles[k] = '0;
            end
            dir_inverse = 1'b0;
            scale_inv = SCALE_INV_RST;
            final_sc = FINAL_SC_RST;
            results_due.delete();
            mismatch_count = 0;
            pending <= 0;
            errors <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DIRECTION:   dir_inverse = cfg_data[0];
                    CFG_SCALE_INV:   scale_inv = cfg_data;
                    CFG_FINAL_SCALE: final_sc = cfg_data;
                    default:         ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                func = s_tuser;
                idx = s_tdata[8:0];
                val = s_tdata[24:9];
                want.kind = func;
                want.residue = '0;
                case (func)
                    FUNC_LOAD_COEFF: coeffs[idx] = {{16{val[15]}}, val};
                    FUNC_LOAD_TW:    twiddles[idx] = val[13:0];
                    FUNC_RUN:
                    begin
                        if (dir_inverse)
                            ntt_inverse_pass();
                        else
                            ntt_forward_pass();
                        for (int k = 0; k < COEFF_COUNT; k++)
                            coeffs[k] = residue(coeffs[k]);
                    end
                    default:         want.residue = 14'(residue(coeffs[idx]));
                endcase
                results_due.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with none due: kind %0d data %0h",
                                 $realtime, m_tuser, m_tdata);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (m_tuser !== want.kind || m_tdata !== {2'b00, want.residue})
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: kind exp %0d got %0d, value exp %0d got %0d",
                                     $realtime, want.kind, m_tuser, want.residue, m_tdata);
                    end
                end
            end
            pending <= results_due.size();
            errors <= mismatch_count;
        end
    end

endmodule

/* test/tb_ntt_with_kred_reduction.sv */
// Testbench top for the 512-point NTT block: clock, reset, stimulus and verdict.
// Depends on ntt_kred_pkg, ntt_with_kred_reduction and ntt_with_kred_reduction_checker.
`timescale 1ns / 1ps

module tb_ntt_with_kred_reduction;
    import ntt_kred_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [13:0] cfg_data;
    int          pending;
    int          errors;
    logic        calm;

    ntt_with_kred_reduction DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ntt_with_kred_reduction_checker coeff_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // stall the result side
    always @(posedge clk or negedge rst_n)
    begin
        int stall;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall = 0;
        end
        else if (stall > 0)
        begin
            m_tready <= 1'b0;
            stall--;
        end
        else
        begin
            stall = pick_gap();
            m_tready <= (stall == 0);
            if (stall > 0)
                stall--;
        end
    end

    task automatic send_item(input logic [1:0] func, input int idx, input logic [15:0] word);
        int gap;
        if ($urandom_range(0, 149) == 0)
            calm = ~calm;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {7'd0, word, 9'(idx)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending != 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic dir, input logic [13:0] sinv,
                                 input logic [13:0] fsc);
        s_tvalid <= 1'b0;
        wait_drained();
        write_reg(CFG_DIRECTION, {13'd0, dir});
        write_reg(CFG_SCALE_INV, sinv);
        write_reg(CFG_FINAL_SCALE, fsc);
    endtask

    initial
    begin
        logic [13:0] sinv_set [7];
        logic [13:0] fsc_set [7];
        logic        dir_set [7];
        int          r;
        dir_set = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        sinv_set = '{14'd8193, 14'd8193, 14'd8193, 14'd0, 14'd12288,
                     14'($urandom_range(0, 16383)), 14'h3fff};
        fsc_set = '{14'd1, 14'd1, 14'd12288, 14'd0, 14'd0,
                    14'($urandom_range(0, 16383)), 14'h3fff};
        calm = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_LOAD_COEFF;
        cfg_valid = 1'b0;
        cfg_index = CFG_DIRECTION;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill both stores before anything reads them
        for (int k = 0; k < COEFF_COUNT; k++)
        begin
            send_item(FUNC_LOAD_COEFF, k, pick_word());
            send_item(FUNC_LOAD_TW, k, pick_word());
        end

        send_item(FUNC_READ, 0, 16'h0);
        send_item(FUNC_READ, 511, 16'hffff);
        send_item(FUNC_LOAD_COEFF, 0, 16'h8000);
        send_item(FUNC_LOAD_COEFF, 511, 16'h7fff);
        send_item(FUNC_LOAD_COEFF, 256, 16'hffff);
        send_item(FUNC_READ, 0, 16'h0);
        send_item(FUNC_READ, 511, 16'h0);
        send_item(FUNC_READ, 256, 16'h0);
        send_item(FUNC_LOAD_TW, 1, 16'hffff);
        send_item(FUNC_LOAD_TW, 511, 16'h8000);
        send_item(FUNC_LOAD_TW, 0, 16'h3fff);

        for (int p = 0; p < 7; p++)
        begin
            apply_setting(dir_set[p], sinv_set[p], fsc_set[p]);
            for (int n = 0; n < 110; n++)
            begin
                r = $urandom_range(0, 9);
                if (r < 3)
                    send_item(FUNC_LOAD_COEFF, $urandom_range(0, 511), pick_word());
                else if (r < 5)
                    send_item(FUNC_LOAD_TW, $urandom_range(0, 511), pick_word());
                else
                    send_item(FUNC_READ, $urandom_range(0, 511), pick_word());
            end
            send_item(FUNC_RUN, $urandom_range(0, 511), pick_word());
            for (int n = 0; n < 10; n++)
                send_item(FUNC_READ, $urandom_range(0, 511), pick_word());
        end

        s_tvalid <= 1'b0;
        wait_drained();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ntt_kred_pkg.sv
rtl/ntt_kred_ram.sv
rtl/ntt_kred_canon.sv
rtl/ntt_with_kred_reduction.sv
rtl/ntt_kred_checker.sv
test/ntt_with_kred_reduction_checker.sv
test/tb_ntt_with_kred_reduction.sv
